// ===== design/ipcre_pkg.sv =====
// ----------------------------------------------------------------------------
// IPC rendezvous endpoint package
// Operation codes, endpoint status codes and ring selectors that the
// endpoint logic shares.
// ----------------------------------------------------------------------------
package ipcre_pkg;

  // Operation codes carried on the mode field.
  localparam logic [1:0] MODE_SEND    = 2'd0;
  localparam logic [1:0] MODE_RECEIVE = 2'd1;
  localparam logic [1:0] MODE_REPLY   = 2'd2;
  localparam logic [1:0] MODE_CANCEL  = 2'd3;

  // Endpoint status codes.
  localparam logic [1:0] EP_IDLE          = 2'd0;
  localparam logic [1:0] EP_SENDERS_WAIT  = 2'd1;
  localparam logic [1:0] EP_RECEIVERS_WAIT = 2'd2;

  // Ring selector, the top bit of the shared waiter memory address.
  localparam logic RING_SND = 1'b0;
  localparam logic RING_RCV = 1'b1;

endpackage

// ===== design/ipc_rendezvous_endpoint_unit.sv =====
// ----------------------------------------------------------------------------
// IPC rendezvous endpoint unit
// Two FIFO rings of blocked thread ids, one pending reply target, and a
// small sequencer around one shared waiter memory and one id comparator.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is one operation (mode_i, thread_id_i). It is accepted at a
//   rising edge where start is high and busy is low. Every transaction yields
//   exactly one result, shown for a single cycle with done_o high; the
//   receiver cannot stall, so it must sample the result in that cycle.
//   Sequencing:
//     push, dropped push, reply : done_o in the cycle after acceptance, and busy
//                                 stays low, so one such transaction a cycle.
//     send/receive with a match : via ST_POP; the pop reads the waiter memory
//                                 and its registered read data is the partner.
//     cancel                    : ST_WALK goes over the sender ring, then the
//                                 receiver ring, as the comparator walks and
//                                 compacts one entry a cycle.
//   sender_count_o, receiver_count_o, endpoint_state_o and reply_outstanding_o
//   follow the live queue state and are valid whenever done_o is high.
//   Reset empties both rings and clears the reply target; the ring storage
//   itself is not cleared, since only entries below the fill are ever read.
// ----------------------------------------------------------------------------
module ipc_rendezvous_endpoint_unit #(
  parameter int WAITER_DEPTH   = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [1:0]                               mode_i,
  input  logic [THREAD_ID_BITS-1:0]                thread_id_i,
  output logic                                     done_o,
  output logic                                     matched_o,
  output logic [THREAD_ID_BITS-1:0]                partner_id_o,
  output logic                                     queue_full_drop_o,
  output logic [1:0]                               endpoint_state_o,
  output logic [$clog2(WAITER_DEPTH+1)-1:0]        sender_count_o,
  output logic [$clog2(WAITER_DEPTH+1)-1:0]        receiver_count_o,
  output logic                                     reply_outstanding_o
);

  localparam int IW = $clog2(WAITER_DEPTH);
  localparam int CW = $clog2(WAITER_DEPTH + 1);
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] FULL_FILL = CW'(WAITER_DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(WAITER_DEPTH - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx);
    adv = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  logic [1:0]                state_q, state_d;
  logic [1:0]                mode_q, mode_d;
  logic [THREAD_ID_BITS-1:0] tid_q, tid_d;

  logic [IW-1:0] shead_q, shead_d, stail_q, stail_d;
  logic [IW-1:0] rhead_q, rhead_d, rtail_q, rtail_d;
  logic [CW-1:0] sfill_q, sfill_d, rfill_q, rfill_d;

  logic [THREAD_ID_BITS-1:0] reply_target_q, reply_target_d;
  logic                      reply_valid_q, reply_valid_d;

  // Cancel walk: ring under compaction, read and write pointers, entries
  // still to read, entries kept, and a flag for read data in flight.
  logic          ring_q, ring_d;
  logic [IW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0] left_q, left_d, kept_q, kept_d;
  logic          pend_q, pend_d;

  logic                      done_q, done_d;
  logic                      matched_q, matched_d;
  logic [THREAD_ID_BITS-1:0] partner_q, partner_d;
  logic                      drop_q, drop_d;

  // Shared waiter memory: sender ring in the lower half, receiver ring above.
  logic [THREAD_ID_BITS-1:0] mem_q [2**AW];
  logic [THREAD_ID_BITS-1:0] rd_q;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_wa, mem_ra;
  logic [THREAD_ID_BITS-1:0] mem_wd;

  logic accept;
  assign accept = start && !busy;

  always_comb begin
    state_d        = state_q;
    mode_d         = mode_q;
    tid_d          = tid_q;
    shead_d        = shead_q;
    stail_d        = stail_q;
    sfill_d        = sfill_q;
    rhead_d        = rhead_q;
    rtail_d        = rtail_q;
    rfill_d        = rfill_q;
    reply_target_d = reply_target_q;
    reply_valid_d  = reply_valid_q;
    ring_d         = ring_q;
    rp_d           = rp_q;
    wp_d           = wp_q;
    left_d         = left_q;
    kept_d         = kept_q;
    pend_d         = 1'b0;
    done_d         = 1'b0;
    matched_d      = 1'b0;
    partner_d      = '0;
    drop_d         = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wa         = '0;
    mem_ra         = '0;
    mem_wd         = thread_id_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d = mode_i;
          tid_d  = thread_id_i;
          case (mode_i)
            ipcre_pkg::MODE_SEND: begin
              if (rfill_q != '0) begin
                mem_re  = 1'b1;
                mem_ra  = {ipcre_pkg::RING_RCV, rhead_q};
                rhead_d = adv(rhead_q);
                rfill_d = rfill_q - 1'b1;
                state_d = ST_POP;
              end else if (sfill_q == FULL_FILL) begin
                done_d = 1'b1;
                drop_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = {ipcre_pkg::RING_SND, stail_q};
                stail_d = adv(stail_q);
                sfill_d = sfill_q + 1'b1;
                done_d  = 1'b1;
              end
            end
            ipcre_pkg::MODE_RECEIVE: begin
              if (sfill_q != '0) begin
                mem_re  = 1'b1;
                mem_ra  = {ipcre_pkg::RING_SND, shead_q};
                shead_d = adv(shead_q);
                sfill_d = sfill_q - 1'b1;
                state_d = ST_POP;
              end else if (rfill_q == FULL_FILL) begin
                done_d = 1'b1;
                drop_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = {ipcre_pkg::RING_RCV, rtail_q};
                rtail_d = adv(rtail_q);
                rfill_d = rfill_q + 1'b1;
                done_d  = 1'b1;
              end
            end
            ipcre_pkg::MODE_REPLY: begin
              done_d = 1'b1;
              if (reply_valid_q) begin
                matched_d      = 1'b1;
                partner_d      = reply_target_q;
                reply_valid_d  = 1'b0;
                reply_target_d = '0;
              end
            end
            default: begin
              ring_d  = ipcre_pkg::RING_SND;
              rp_d    = shead_q;
              wp_d    = shead_q;
              left_d  = sfill_q;
              kept_d  = '0;
              state_d = ST_WALK;
            end
          endcase
        end
      end

      ST_POP: begin
        done_d         = 1'b1;
        matched_d      = 1'b1;
        partner_d      = rd_q;
        reply_valid_d  = 1'b1;
        reply_target_d = (mode_q == ipcre_pkg::MODE_SEND) ? tid_q : rd_q;
        state_d        = ST_IDLE;
      end

      ST_WALK: begin
        if (left_q != '0) begin
          mem_re = 1'b1;
          mem_ra = {ring_q, rp_q};
          rp_d   = adv(rp_q);
          left_d = left_q - 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q && (rd_q != tid_q)) begin
          mem_we = 1'b1;
          mem_wa = {ring_q, wp_q};
          mem_wd = rd_q;
          wp_d   = adv(wp_q);
          kept_d = kept_q + 1'b1;
        end
        if ((left_q == '0) && !pend_q) begin
          if (ring_q == ipcre_pkg::RING_SND) begin
            stail_d = wp_q;
            sfill_d = kept_q;
            ring_d  = ipcre_pkg::RING_RCV;
            rp_d    = rhead_q;
            wp_d    = rhead_q;
            left_d  = rfill_q;
            kept_d  = '0;
          end else begin
            rtail_d = wp_q;
            rfill_d = kept_q;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      shead_q        <= '0;
      stail_q        <= '0;
      sfill_q        <= '0;
      rhead_q        <= '0;
      rtail_q        <= '0;
      rfill_q        <= '0;
      reply_target_q <= '0;
      reply_valid_q  <= 1'b0;
      left_q         <= '0;
      pend_q         <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      shead_q        <= shead_d;
      stail_q        <= stail_d;
      sfill_q        <= sfill_d;
      rhead_q        <= rhead_d;
      rtail_q        <= rtail_d;
      rfill_q        <= rfill_d;
      reply_target_q <= reply_target_d;
      reply_valid_q  <= reply_valid_d;
      left_q         <= left_d;
      pend_q         <= pend_d;
      done_q         <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    tid_q     <= tid_d;
    ring_q    <= ring_d;
    rp_q      <= rp_d;
    wp_q      <= wp_d;
    kept_q    <= kept_d;
    matched_q <= matched_d;
    partner_q <= partner_d;
    drop_q    <= drop_d;
  end

  // Waiter memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  always_comb begin
    if ((sfill_q != '0) && (rfill_q == '0)) begin
      endpoint_state_o = ipcre_pkg::EP_SENDERS_WAIT;
    end else if ((rfill_q != '0) && (sfill_q == '0)) begin
      endpoint_state_o = ipcre_pkg::EP_RECEIVERS_WAIT;
    end else begin
      endpoint_state_o = ipcre_pkg::EP_IDLE;
    end
  end

  assign busy                = (state_q != ST_IDLE);
  assign done_o              = done_q;
  assign matched_o           = matched_q;
  assign partner_id_o        = partner_q;
  assign queue_full_drop_o   = drop_q;
  assign sender_count_o      = sfill_q;
  assign receiver_count_o    = rfill_q;
  assign reply_outstanding_o = reply_valid_q;

`ifndef NO_ASSERTIONS
  // At most one ring ever holds waiters.
  a_one_ring_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((sfill_q != '0) && (rfill_q != '0)))
    else $error("both waiter rings are non-empty");

  // No result is presented while an operation is still in progress.
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result strobe while busy");

  // A result never reports both a match and a dropped push.
  a_match_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(matched_o && queue_full_drop_o))
    else $error("match and drop in one result");

  // A send that finds no receiver and room queues the sender at once.
  a_send_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == ipcre_pkg::MODE_SEND) && (rfill_q == '0) &&
     (sfill_q != FULL_FILL))
    |=> (done_o && !matched_o && (sfill_q == $past(sfill_q) + 1'b1)))
    else $error("send push did not complete in one cycle");

  // A reply with a caller pending hands it back and clears the target.
  a_reply_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == ipcre_pkg::MODE_REPLY) && reply_valid_q)
    |=> (done_o && matched_o && !reply_outstanding_o))
    else $error("reply did not release the pending caller");
`endif

endmodule

// ===== dv/ipcre_checker.sv =====
// ----------------------------------------------------------------------------
// IPC rendezvous endpoint checker
// Watches the request and result channels of the endpoint. It keeps its own
// copy of both waiter rings and the pending reply target, predicts the result
// of every accepted transaction, and compares each result strobe in order.
// ----------------------------------------------------------------------------
module ipcre_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] mode_i,
  input  logic [7:0] thread_id_i,
  input  logic       done_o,
  input  logic       matched_o,
  input  logic [7:0] partner_id_o,
  input  logic       queue_full_drop_o,
  input  logic [1:0] endpoint_state_o,
  input  logic [4:0] sender_count_o,
  input  logic [4:0] receiver_count_o,
  input  logic       reply_outstanding_o,
  output int         fail_count,
  output int         pending_count
);

  localparam int RING_DEPTH = 16;

  typedef struct packed {
    logic       matched;
    logic [7:0] partner;
    logic       drop;
    logic [1:0] ep_state;
    logic [4:0] senders;
    logic [4:0] receivers;
    logic       reply_held;
  } ep_result_t;

  logic [7:0] blocked_senders[$];
  logic [7:0] blocked_receivers[$];
  logic [7:0] reply_caller;
  logic       caller_held;
  ep_result_t expected_results[$];

  int n_fail = 0;
  int n_pend = 0;

  assign fail_count    = n_fail;
  assign pending_count = n_pend;

  // Removes every copy of an id and keeps the order of the rest.
  function automatic void purge_id(ref logic [7:0] ring[$], input logic [7:0] id);
    logic [7:0] kept[$];
    foreach (ring[i]) begin
      if (ring[i] != id) kept.push_back(ring[i]);
    end
    ring = kept;
  endfunction

  // Applies one operation to the predicted endpoint and returns its result.
  function automatic ep_result_t rendezvous(input logic [1:0] op, input logic [7:0] id);
    ep_result_t r;
    r = '0;
    case (op)
      ipcre_pkg::MODE_SEND: begin
        if (blocked_receivers.size() != 0) begin
          r.partner    = blocked_receivers.pop_front();
          r.matched    = 1'b1;
          reply_caller = id;
          caller_held  = 1'b1;
        end else if (blocked_senders.size() >= RING_DEPTH) begin
          r.drop = 1'b1;
        end else begin
          blocked_senders.push_back(id);
        end
      end
      ipcre_pkg::MODE_RECEIVE: begin
        if (blocked_senders.size() != 0) begin
          r.partner    = blocked_senders.pop_front();
          r.matched    = 1'b1;
          reply_caller = r.partner;
          caller_held  = 1'b1;
        end else if (blocked_receivers.size() >= RING_DEPTH) begin
          r.drop = 1'b1;
        end else begin
          blocked_receivers.push_back(id);
        end
      end
      ipcre_pkg::MODE_REPLY: begin
        if (caller_held) begin
          r.partner    = reply_caller;
          r.matched    = 1'b1;
          caller_held  = 1'b0;
          reply_caller = '0;
        end
      end
      default: begin
        purge_id(blocked_senders, id);
        purge_id(blocked_receivers, id);
      end
    endcase
    if (blocked_senders.size() != 0 && blocked_receivers.size() == 0) begin
      r.ep_state = ipcre_pkg::EP_SENDERS_WAIT;
    end else if (blocked_receivers.size() != 0 && blocked_senders.size() == 0) begin
      r.ep_state = ipcre_pkg::EP_RECEIVERS_WAIT;
    end else begin
      r.ep_state = ipcre_pkg::EP_IDLE;
    end
    r.senders    = 5'(blocked_senders.size());
    r.receivers  = 5'(blocked_receivers.size());
    r.reply_held = caller_held;
    return r;
  endfunction

  // Results are checked before the transaction accepted at the same edge is
  // predicted, since that transaction cannot answer in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    ep_result_t got;
    ep_result_t want;
    int         fails;
    if (!rst_ni) begin
      blocked_senders.delete();
      blocked_receivers.delete();
      expected_results.delete();
      reply_caller = '0;
      caller_held  = 1'b0;
      n_pend <= 0;
    end else begin
      fails = n_fail;
      if (done_o) begin
        got.matched    = matched_o;
        got.partner    = partner_id_o;
        got.drop       = queue_full_drop_o;
        got.ep_state   = endpoint_state_o;
        got.senders    = sender_count_o;
        got.receivers  = receiver_count_o;
        got.reply_held = reply_outstanding_o;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result without a pending transaction: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (start && !busy) expected_results.push_back(rendezvous(mode_i, thread_id_i));
      n_fail <= fails;
      n_pend <= expected_results.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// IPC rendezvous endpoint testbench
// Drives send, receive, reply and cancel transactions into the endpoint in
// random bursts, first a directed pass over the corner cases, then random
// scenarios that fill, overflow, cancel and drain both waiter rings. A
// checker beside the endpoint predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_OPS = 1650;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic [1:0] mode_i      = ipcre_pkg::MODE_REPLY;
  logic [7:0] thread_id_i = '0;

  logic       busy;
  logic       done_o;
  logic       matched_o;
  logic [7:0] partner_id_o;
  logic       queue_full_drop_o;
  logic [1:0] endpoint_state_o;
  logic [4:0] sender_count_o;
  logic [4:0] receiver_count_o;
  logic       reply_outstanding_o;

  int fail_count;
  int pending_count;

  // Transactions left in the current burst, and random transactions issued.
  int burst_left = 0;
  int random_ops = 0;

  always #5 clk_i = ~clk_i;

  ipc_rendezvous_endpoint_unit #(
    .WAITER_DEPTH  (16),
    .THREAD_ID_BITS(8)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .thread_id_i        (thread_id_i),
    .done_o             (done_o),
    .matched_o          (matched_o),
    .partner_id_o       (partner_id_o),
    .queue_full_drop_o  (queue_full_drop_o),
    .endpoint_state_o   (endpoint_state_o),
    .sender_count_o     (sender_count_o),
    .receiver_count_o   (receiver_count_o),
    .reply_outstanding_o(reply_outstanding_o)
  );

  ipcre_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .thread_id_i        (thread_id_i),
    .done_o             (done_o),
    .matched_o          (matched_o),
    .partner_id_o       (partner_id_o),
    .queue_full_drop_o  (queue_full_drop_o),
    .endpoint_state_o   (endpoint_state_o),
    .sender_count_o     (sender_count_o),
    .receiver_count_o   (receiver_count_o),
    .reply_outstanding_o(reply_outstanding_o),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  // Watchdog. The slowest legal run is a cancel after every transaction,
  // each walking both rings and followed by a sender gap.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Issues one transaction and returns at the edge that accepts it. Between
  // bursts the request line usually drops for a random gap while the payload ports
  // carry noise. Within a burst start stays high from one transaction to the
  // next, so it never gets two assignments in one time step.
  task automatic issue_op(input logic [1:0] op, input logic [7:0] id);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) begin
          mode_i      <= 2'($urandom);
          thread_id_i <= 8'($urandom);
          @(posedge clk_i);
        end
      end
      // Now and then a long burst gives a stretch without any idling.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    start       <= 1'b1;
    mode_i      <= op;
    thread_id_i <= id;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    burst_left--;
  endtask

  // Holds off new transactions until every predicted result has come back.
  // One edge passes first so that the last accepted transaction is counted.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Ids mostly come from a small pool so that cancels and duplicates hit
  // often; the rest are the extremes or fully random so every bit toggles.
  function automatic logic [7:0] pick_id();
    case ($urandom_range(0, 3))
      0: begin
        return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1, 2: begin
        return 8'($urandom_range(0, 7));
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ipcre_pkg::MODE_SEND;
    if (r < 70) return ipcre_pkg::MODE_RECEIVE;
    if (r < 85) return ipcre_pkg::MODE_REPLY;
    return ipcre_pkg::MODE_CANCEL;
  endfunction

  initial begin
    logic [7:0] id;
    logic [1:0] flood_op;
    logic [1:0] drain_op;
    int         scenario;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass. A reply with nothing pending comes first.
    issue_op(ipcre_pkg::MODE_REPLY, 8'hFF);
    // Sixteen senders fill the ring; one id shows up several times so that
    // the later cancel has to remove more than one entry and compact.
    for (int i = 0; i < 16; i++) begin
      if (i == 0) id = 8'h00;
      else if (i == 1) id = 8'hFF;
      else if (i % 3 == 0) id = 8'h5A;
      else id = 8'(i * 17);
      issue_op(ipcre_pkg::MODE_SEND, id);
    end
    // The ring is full, so this push is dropped.
    issue_op(ipcre_pkg::MODE_SEND, 8'h77);
    // Receives pop the oldest senders; the second match replaces the reply
    // target that the first one left behind.
    issue_op(ipcre_pkg::MODE_RECEIVE, 8'h77);
    issue_op(ipcre_pkg::MODE_CANCEL, 8'h5A);
    issue_op(ipcre_pkg::MODE_RECEIVE, 8'h11);
    issue_op(ipcre_pkg::MODE_REPLY, 8'h00);
    issue_op(ipcre_pkg::MODE_REPLY, 8'h3C);
    // Cancel of an id that waits nowhere still compacts the rings.
    issue_op(ipcre_pkg::MODE_CANCEL, 8'hC3);
    issue_op(ipcre_pkg::MODE_CANCEL, 8'hFF);
    settle();

    // Random scenarios until the budget of random transactions is spent.
    while (random_ops < RANDOM_OPS) begin
      scenario = $urandom_range(0, 9);
      if (scenario <= 5) begin
        // Mixed traffic with random content.
        repeat ($urandom_range(8, 30)) begin
          issue_op(pick_op(), pick_id());
          random_ops++;
        end
      end else if (scenario <= 8) begin
        // Flood one side past full, cancel a few ids, then drain it from the
        // other side and answer the last caller.
        flood_op = $urandom_range(0, 1) ? ipcre_pkg::MODE_SEND : ipcre_pkg::MODE_RECEIVE;
        drain_op = (flood_op == ipcre_pkg::MODE_SEND) ? ipcre_pkg::MODE_RECEIVE
                                                      : ipcre_pkg::MODE_SEND;
        repeat ($urandom_range(17, 24)) begin
          issue_op(flood_op, pick_id());
          random_ops++;
        end
        repeat ($urandom_range(0, 3)) begin
          issue_op(ipcre_pkg::MODE_CANCEL, pick_id());
          random_ops++;
        end
        repeat ($urandom_range(4, 20)) begin
          issue_op(drain_op, pick_id());
          random_ops++;
        end
        issue_op(ipcre_pkg::MODE_REPLY, pick_id());
        random_ops++;
      end else begin
        // Stray replies and cancels, then a full pause.
        repeat ($urandom_range(1, 5)) begin
          issue_op($urandom_range(0, 1) ? ipcre_pkg::MODE_REPLY
                                        : ipcre_pkg::MODE_CANCEL, pick_id());
          random_ops++;
        end
        settle();
      end
    end

    // Let the last results arrive, then allow for a cancel walking a full
    // ring before the verdict.
    settle();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
